// ===== hdl/cfns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfns_pkg
// Shared types and constants of the cover-fit nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package cfns_pkg;

  // Limits of the effective dimensions.
  localparam int unsigned MAX_SRC_W   = 256;
  localparam int unsigned MAX_SRC_H   = 256;
  localparam int unsigned MAX_DST_DIM = 4096;

  // Field and register widths.
  localparam int unsigned SRC_DIM_W  = 9;
  localparam int unsigned DST_DIM_W  = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned RGB_W      = 3 * CHAN_W;
  localparam int unsigned STORE_AW   = 16;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned OUT_OFF_W  = 24;
  localparam int unsigned ARGB_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DST_DIM_W;

  // Crop setup widths: product of a target and a source dimension, the
  // scaled size, half of the overhang, and the per-pixel dividend.
  localparam int unsigned PROD_W = DST_DIM_W + SRC_DIM_W;
  localparam int unsigned SDIM_W = $clog2(MAX_DST_DIM * MAX_SRC_W) + 1;
  localparam int unsigned OFF_W  = SDIM_W - 1;
  localparam int unsigned NUM_W  = SDIM_W + SRC_DIM_W;
  localparam int unsigned QW     = $clog2((MAX_SRC_W > MAX_SRC_H) ? MAX_SRC_W : MAX_SRC_H);
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  localparam logic [ARGB_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE = 3'd4;

  // Register values after reset.
  localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 9'd256;
  localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 9'd256;
  localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 13'd1024;
  localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 13'd768;
  localparam logic [DST_DIM_W-1:0] RST_DST_STRIDE = 13'd1024;

  // Word kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [STORE_AW-1:0]  pixel_index;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [COORD_W-1:0]   dest_x;
    logic [COORD_W-1:0]   dest_y;
  } in_word_t;

  typedef struct packed {
    logic [OUT_OFF_W-1:0] dest_offset;
    logic [ARGB_W-1:0]    pixel_argb;
  } out_word_t;

  // Crop geometry handed from the setup unit to the pixel pipeline.
  typedef struct packed {
    logic [SRC_DIM_W-1:0] iw;
    logic [SRC_DIM_W-1:0] ih;
    logic [DST_DIM_W-1:0] cw;
    logic [DST_DIM_W-1:0] ch;
    logic [DST_DIM_W-1:0] stride;
    logic [SDIM_W-1:0]    sw;
    logic [SDIM_W-1:0]    sh;
    logic [OFF_W-1:0]     oxm;
    logic [OFF_W-1:0]     oym;
    logic                 draw_ok;
    logic                 ready;
  } crop_t;

  typedef enum logic [2:0] {
    SU_MUL,
    SU_CMP,
    SU_DIV,
    SU_FIN,
    SU_RUN
  } setup_state_e;

endpackage

// ===== hdl/cfns_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cfns_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cfns_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfns_setup
// Configuration registers and the crop setup: scaled size along the long
// axis by a serial divider, and the centering offset of the overhang.
// ----------------------------------------------------------------------------
module cfns_setup
  import cfns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output crop_t                 crop_o
);

  logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [DST_DIM_W-1:0] dst_w_q, dst_h_q, stride_q;

  setup_state_e state_q, state_d;
  logic [PROD_W-1:0]    p1_q, p1_d, p2_q, p2_d, dq_q, dq_d;
  logic [SRC_DIM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 fit_h_q, fit_h_d;
  logic [SDIM_W-1:0]    sw_q, sw_d, sh_q, sh_d;
  logic [OFF_W-1:0]     oxm_q, oxm_d, oym_q, oym_d;

  logic [SRC_DIM_W-1:0] iw, ih, dvs;
  logic [DST_DIM_W-1:0] cw, ch;
  logic [SRC_DIM_W:0]   rem_sh;
  logic [PROD_W-1:0]    over;

  // Saturated dimensions.
  assign iw = (src_w_q > SRC_DIM_W'(MAX_SRC_W)) ? SRC_DIM_W'(MAX_SRC_W) : src_w_q;
  assign ih = (src_h_q > SRC_DIM_W'(MAX_SRC_H)) ? SRC_DIM_W'(MAX_SRC_H) : src_h_q;
  assign cw = (dst_w_q > DST_DIM_W'(MAX_DST_DIM)) ? DST_DIM_W'(MAX_DST_DIM) : dst_w_q;
  assign ch = (dst_h_q > DST_DIM_W'(MAX_DST_DIM)) ? DST_DIM_W'(MAX_DST_DIM) : dst_h_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RST_SRC_WIDTH;
      src_h_q  <= RST_SRC_HEIGHT;
      dst_w_q  <= RST_DST_WIDTH;
      dst_h_q  <= RST_DST_HEIGHT;
      stride_q <= RST_DST_STRIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q  <= cfg_data_i[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q  <= cfg_data_i[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_q  <= cfg_data_i;
        REG_DST_HEIGHT: dst_h_q  <= cfg_data_i;
        REG_DST_STRIDE: stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SU_MUL;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the setup.
  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    fit_h_q <= fit_h_d;
    sw_q    <= sw_d;
    sh_q    <= sh_d;
    oxm_q   <= oxm_d;
    oym_q   <= oym_d;
  end

  // The scaled image fills the height when the target is relatively taller.
  assign dvs    = fit_h_q ? ih : iw;
  assign rem_sh = {rem_q, dq_q[PROD_W-1]};
  assign over   = dq_q - (fit_h_q ? PROD_W'(cw) : PROD_W'(ch));

  // Next state and datapath values.
  always_comb begin
    state_d = state_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    fit_h_d = fit_h_q;
    sw_d    = sw_q;
    sh_d    = sh_q;
    oxm_d   = oxm_q;
    oym_d   = oym_q;
    unique case (state_q)
      SU_MUL: begin
        p1_d    = PROD_W'(ch) * PROD_W'(iw);
        p2_d    = PROD_W'(cw) * PROD_W'(ih);
        state_d = SU_CMP;
      end
      SU_CMP: begin
        fit_h_d = (p1_q >= p2_q);
        dq_d    = (p1_q >= p2_q) ? p1_q : p2_q;
        rem_d   = '0;
        cnt_d   = CNT_W'(PROD_W - 1);
        state_d = SU_DIV;
      end
      SU_DIV: begin
        // One restoring step: the quotient bit shifts in from the right.
        if (rem_sh >= {1'b0, dvs}) begin
          rem_d = SRC_DIM_W'(rem_sh - {1'b0, dvs});
          dq_d  = {dq_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[SRC_DIM_W-1:0];
          dq_d  = {dq_q[PROD_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = SU_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SU_FIN: begin
        // The overhang is never negative, so halving it truncates toward zero.
        if (fit_h_q) begin
          sw_d  = dq_q[SDIM_W-1:0];
          sh_d  = SDIM_W'(ch);
          oxm_d = over[OFF_W:1];
          oym_d = '0;
        end else begin
          sw_d  = SDIM_W'(cw);
          sh_d  = dq_q[SDIM_W-1:0];
          oxm_d = '0;
          oym_d = over[OFF_W:1];
        end
        state_d = SU_RUN;
      end
      SU_RUN: begin
        state_d = SU_RUN;
      end
      default: begin
        state_d = SU_MUL;
      end
    endcase
    // Any register write starts the setup over.
    if (cfg_we_i) begin
      state_d = SU_MUL;
    end
  end

  // Geometry seen by the pixel pipeline.
  always_comb begin
    crop_o.iw      = iw;
    crop_o.ih      = ih;
    crop_o.cw      = cw;
    crop_o.ch      = ch;
    crop_o.stride  = stride_q;
    crop_o.sw      = sw_q;
    crop_o.sh      = sh_q;
    crop_o.oxm     = oxm_q;
    crop_o.oym     = oym_q;
    crop_o.draw_ok = (iw != '0) && (ih != '0) && (cw != '0) && (ch != '0);
    crop_o.ready   = (state_q == SU_RUN);
  end

endmodule

// ===== hdl/cover_fit_nearest_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cover_fit_nearest_scaler
// A render word passes the input register, offset stage, product stage,
// 8 divider stages and the RAM read. Throughput: one word per cycle unless
// the output stalls or the setup runs; the pipelined per-pixel dividers and
// the single image RAM (one load write or one render read per cycle) set it.
// Reset and every register write run the crop setup (serial divider),
// during which no word is accepted. The image store is not cleared by reset.
// ----------------------------------------------------------------------------
module cover_fit_nearest_scaler
  import cfns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NST = 3 + QW;

  typedef struct packed {
    logic                 kind;
    logic [STORE_AW-1:0]  pidx;
    logic [RGB_W-1:0]     rgb;
    logic                 draw;
    logic [OUT_OFF_W-1:0] offset;
    logic [SDIM_W-1:0]    ax;
    logic [SDIM_W-1:0]    ay;
  } pos_t;

  typedef struct packed {
    logic                 kind;
    logic [STORE_AW-1:0]  pidx;
    logic [RGB_W-1:0]     rgb;
    logic                 draw;
    logic [OUT_OFF_W-1:0] offset;
    logic                 cx;
    logic                 cy;
    logic [NUM_W-1:0]     remx;
    logic [NUM_W-1:0]     remy;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
  } div_t;

  crop_t crop;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;
  logic           out_vld_q;
  logic           out_en;
  logic           in_acc;

  in_word_t s0_q;
  pos_t     s1_q, s1_d;
  div_t     s2_q, s2_d;
  div_t     dv_q [QW];
  div_t     dv_d [QW];
  div_t     sm;

  logic [OUT_OFF_W-1:0] out_off_q;
  logic [QW-1:0]        sx, sy;
  logic [STORE_AW-1:0]  raddr;
  logic [RGB_W-1:0]     rdata;
  logic                 ram_we, ram_re;

  // Crop setup and configuration registers.
  cfns_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .crop_o      (crop)
  );

  // Stage enables: a stage loads when it is empty or its word moves on.
  assign out_en = !out_vld_q || out_ready_i;
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_en;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0] && crop.ready;
  assign in_acc     = in_valid_i && in_ready_o;

  // Valid bits of the pipeline and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_acc;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_en) begin
        out_vld_q <= vld_q[NST-1] && (sm.kind == KIND_RENDER) && sm.draw;
      end
    end
  end

  // Offset stage: target window test, crop shift and destination offset.
  always_comb begin
    s1_d.kind   = s0_q.kind;
    s1_d.pidx   = s0_q.pixel_index;
    s1_d.rgb    = {s0_q.red, s0_q.green, s0_q.blue};
    s1_d.draw   = crop.draw_ok && ({1'b0, s0_q.dest_x} < crop.cw)
                  && ({1'b0, s0_q.dest_y} < crop.ch);
    s1_d.offset = OUT_OFF_W'(s0_q.dest_y) * OUT_OFF_W'(crop.stride)
                  + OUT_OFF_W'(s0_q.dest_x);
    s1_d.ax     = SDIM_W'(s0_q.dest_x) + SDIM_W'(crop.oxm);
    s1_d.ay     = SDIM_W'(s0_q.dest_y) + SDIM_W'(crop.oym);
  end

  // Product stage: dividends and the clamp at the far image edge.
  always_comb begin
    s2_d.kind   = s1_q.kind;
    s2_d.pidx   = s1_q.pidx;
    s2_d.rgb    = s1_q.rgb;
    s2_d.draw   = s1_q.draw;
    s2_d.offset = s1_q.offset;
    s2_d.cx     = (s1_q.ax >= crop.sw);
    s2_d.cy     = (s1_q.ay >= crop.sh);
    s2_d.remx   = NUM_W'(s1_q.ax) * NUM_W'(crop.iw);
    s2_d.remy   = NUM_W'(s1_q.ay) * NUM_W'(crop.ih);
    s2_d.qx     = '0;
    s2_d.qy     = '0;
  end

  // Divider stages: one quotient bit per stage, most significant first.
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int unsigned Bit = QW - 1 - s;
    div_t        src;
    logic [NUM_W-1:0] dx, dy;

    assign src = (s == 0) ? s2_q : dv_q[(s == 0) ? 0 : s - 1];
    assign dx  = NUM_W'(crop.sw) << Bit;
    assign dy  = NUM_W'(crop.sh) << Bit;

    always_comb begin
      dv_d[s] = src;
      if (src.remx >= dx) begin
        dv_d[s].remx    = src.remx - dx;
        dv_d[s].qx[Bit] = 1'b1;
      end
      if (src.remy >= dy) begin
        dv_d[s].remy    = src.remy - dy;
        dv_d[s].qy[Bit] = 1'b1;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= in_word_i;
    end
    if (en[1]) begin
      s1_q <= s1_d;
    end
    if (en[2]) begin
      s2_q <= s2_d;
    end
    for (int s = 0; s < QW; s++) begin
      if (en[3+s]) begin
        dv_q[s] <= dv_d[s];
      end
    end
    if (out_en) begin
      out_off_q <= sm.offset;
    end
  end

  // Store address: clamped source row and column.
  assign sm    = dv_q[QW-1];
  assign sx    = sm.cx ? QW'(crop.iw - 1'b1) : sm.qx;
  assign sy    = sm.cy ? QW'(crop.ih - 1'b1) : sm.qy;
  assign raddr = STORE_AW'(sy) * STORE_AW'(crop.iw) + STORE_AW'(sx);

  // Loads write and renders read as their word leaves the last divider stage.
  assign ram_we = out_en && vld_q[NST-1] && (sm.kind == KIND_LOAD);
  assign ram_re = out_en;

  cfns_ram #(
    .WIDTH (RGB_W),
    .DEPTH (STORE_DEPTH)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sm.pidx),
    .wdata_i (sm.rgb),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result word.
  assign out_valid_o            = out_vld_q;
  assign out_word_o.dest_offset = out_off_q;
  assign out_word_o.pixel_argb  = ALPHA_OPAQUE | ARGB_W'(rdata);

endmodule

// ===== bench/cover_fit_nearest_scaler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cover_fit_nearest_scaler_tb
// Self-checking bench for the cover-fit nearest-neighbor scaler. Load and
// render words are sent with random gaps, random output stalls and one long
// output hold. A scoreboard keeps its own copy of the image store and the
// registers, predicts each render pixel and compares it field by field.
// ----------------------------------------------------------------------------
module cover_fit_nearest_scaler_tb;
  import cfns_pkg::*;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_DST_STRIDE + 3'd1;

  // Cycles to let the pipeline settle once no pixel is outstanding.
  localparam int unsigned SETTLE_CYCLES = 20;
  // Length of the long output hold.
  localparam int unsigned HOLD_CYCLES = 400;

  // Scoreboard: mirrors the store and registers and predicts render pixels.
  class scaled_pixel_board;
    bit [RGB_W-1:0]     image_mem [STORE_DEPTH];
    bit [SRC_DIM_W-1:0] src_w;
    bit [SRC_DIM_W-1:0] src_h;
    bit [DST_DIM_W-1:0] dst_w;
    bit [DST_DIM_W-1:0] dst_h;
    bit [DST_DIM_W-1:0] stride;
    out_word_t          expected_pixels [$];
    int unsigned        errors;

    function new();
      src_w  = RST_SRC_WIDTH;
      src_h  = RST_SRC_HEIGHT;
      dst_w  = RST_DST_WIDTH;
      dst_h  = RST_DST_HEIGHT;
      stride = RST_DST_STRIDE;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w  = data[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h  = data[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w  = data;
        REG_DST_HEIGHT: dst_h  = data;
        REG_DST_STRIDE: stride = data;
        default: ;
      endcase
    endfunction

    // Effective target size after saturation.
    function longint target_w();
      return (dst_w > MAX_DST_DIM) ? longint'(MAX_DST_DIM) : longint'(dst_w);
    endfunction

    function longint target_h();
      return (dst_h > MAX_DST_DIM) ? longint'(MAX_DST_DIM) : longint'(dst_h);
    endfunction

    // Store index read for a destination pixel, or -1 when nothing is drawn.
    function int source_index_for(bit [COORD_W-1:0] dx, bit [COORD_W-1:0] dy);
      longint iw, ih, cw, ch, x, y, sw, sh, ox, oy, sx, sy;
      iw = (src_w > MAX_SRC_W) ? longint'(MAX_SRC_W) : longint'(src_w);
      ih = (src_h > MAX_SRC_H) ? longint'(MAX_SRC_H) : longint'(src_h);
      cw = target_w();
      ch = target_h();
      x  = longint'(dx);
      y  = longint'(dy);
      if (iw == 0 || ih == 0 || cw == 0 || ch == 0) return -1;
      if (x >= cw || y >= ch) return -1;
      ox = 0;
      oy = 0;
      // Fill the target and crop the overhanging axis around its center.
      if (ch * iw >= cw * ih) begin
        sh = ch;
        sw = ch * iw / ih;
        ox = (cw - sw) / 2;
      end else begin
        sw = cw;
        sh = cw * ih / iw;
        oy = (ch - sh) / 2;
      end
      sy = (y - oy) * ih / sh;
      sx = (x - ox) * iw / sw;
      if (sy < 0) sy = 0;
      else if (sy >= ih) sy = ih - 1;
      if (sx < 0) sx = 0;
      else if (sx >= iw) sx = iw - 1;
      return int'((sy * iw + sx) & 64'hFFFF);
    endfunction

    // Called for every accepted input word.
    function void note_word(in_word_t w);
      int        idx;
      longint    off;
      out_word_t e;
      if (w.kind == KIND_LOAD) begin
        image_mem[w.pixel_index] = {w.red, w.green, w.blue};
        return;
      end
      idx = source_index_for(w.dest_x, w.dest_y);
      if (idx < 0) return;
      off = longint'(w.dest_y) * longint'(stride) + longint'(w.dest_x);
      e.dest_offset = off[OUT_OFF_W-1:0];
      e.pixel_argb  = ALPHA_OPAQUE | {8'h00, image_mem[idx]};
      expected_pixels.push_back(e);
    endfunction

    // Called for every accepted output word.
    function void check_pixel(out_word_t got);
      out_word_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got offset %h argb %h",
                 $time, got.dest_offset, got.pixel_argb);
        return;
      end
      e = expected_pixels.pop_front();
      if (got.dest_offset !== e.dest_offset) begin
        errors++;
        $display("%0t: dest_offset mismatch, expected %h, got %h",
                 $time, e.dest_offset, got.dest_offset);
      end
      if (got.pixel_argb !== e.pixel_argb) begin
        errors++;
        $display("%0t: pixel_argb mismatch, expected %h, got %h",
                 $time, e.pixel_argb, got.pixel_argb);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  scaled_pixel_board sb;
  bit loaded [STORE_DEPTH];
  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_off_req = 1'b0;

  cover_fit_nearest_scaler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("** cover_fit_nearest_scaler: FAILED **");
    $finish;
  end

  // Watch both channels and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(out_word_o);
    end
  end

  // Output side: random stalls, and one long hold when asked for.
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_word_t noise_word();
    in_word_t w;
    w.kind        = 1'($urandom);
    w.pixel_index = STORE_AW'($urandom);
    w.red         = CHAN_W'($urandom);
    w.green       = CHAN_W'($urandom);
    w.blue        = CHAN_W'($urandom);
    w.dest_x      = COORD_W'($urandom);
    w.dest_y      = COORD_W'($urandom);
    return w;
  endfunction

  // Offer one word after an optional gap and wait until it is taken.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = 0;
    if (send_idle && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_pixel(input int unsigned idx, input logic [RGB_W-1:0] rgb);
    in_word_t w;
    w = noise_word();
    w.kind = KIND_LOAD;
    w.pixel_index = STORE_AW'(idx);
    {w.red, w.green, w.blue} = rgb;
    loaded[w.pixel_index] = 1'b1;
    send_word(w);
  endtask

  // Render one pixel; its source pixel is loaded first if it never was.
  task automatic render_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int       idx;
    in_word_t w;
    idx = sb.source_index_for(x, y);
    if (idx >= 0 && !loaded[idx]) load_pixel(idx, RGB_W'($urandom));
    w = noise_word();
    w.kind   = KIND_RENDER;
    w.dest_x = x;
    w.dest_y = y;
    send_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every pixel is back and the pipeline has gone quiet.
  // The first edge lets the monitor note the last accepted word.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_src();
    logic [SRC_DIM_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = SRC_DIM_W'(1);
      1:       v = SRC_DIM_W'(MAX_SRC_W);
      2:       v = SRC_DIM_W'($urandom_range(MAX_SRC_W + 1, 511));
      3:       v = SRC_DIM_W'($urandom_range(1, MAX_SRC_W));
      default: v = SRC_DIM_W'($urandom_range(1, 16));
    endcase
    // Bits above the register width are dropped by the block.
    return {4'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dst();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'(1);
      1:       return CFG_DATA_W'(MAX_DST_DIM);
      2:       return CFG_DATA_W'($urandom_range(MAX_DST_DIM + 1, 8191));
      3:       return CFG_DATA_W'($urandom_range(1, MAX_DST_DIM));
      default: return CFG_DATA_W'($urandom_range(1, 700));
    endcase
  endfunction

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] w;
    write_reg(REG_SRC_WIDTH, pick_src());
    write_reg(REG_SRC_HEIGHT, pick_src());
    w = pick_dst();
    write_reg(REG_DST_WIDTH, w);
    write_reg(REG_DST_HEIGHT, pick_dst());
    case ($urandom_range(0, 4))
      0:       write_reg(REG_DST_STRIDE, '0);
      1:       write_reg(REG_DST_STRIDE, '1);
      2:       write_reg(REG_DST_STRIDE, CFG_DATA_W'($urandom));
      default: write_reg(REG_DST_STRIDE, w);
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_PAST_LAST + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    // Now and then one dimension is zero and nothing is drawn.
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(REG_SRC_WIDTH, '0);
        1:       write_reg(REG_SRC_HEIGHT, '0);
        2:       write_reg(REG_DST_WIDTH, '0);
        default: write_reg(REG_DST_HEIGHT, '0);
      endcase
    end
  endtask

  // Mostly well-formed renders inside the target, plus loads and strays.
  task automatic random_item();
    longint cw, ch;
    cw = sb.target_w();
    ch = sb.target_h();
    case ($urandom_range(0, 9))
      0, 1: load_pixel($urandom_range(0, STORE_DEPTH - 1), RGB_W'($urandom));
      2:    render_at(COORD_W'($urandom), COORD_W'($urandom));
      3: begin
        if (cw > 0 && ch > 0) render_at(COORD_W'(cw - 1), COORD_W'(ch - 1));
        else render_at(COORD_W'($urandom), COORD_W'($urandom));
      end
      default: begin
        if (cw > 0 && ch > 0)
          render_at(COORD_W'($urandom_range(0, 32'(cw - 1))),
                    COORD_W'($urandom_range(0, 32'(ch - 1))));
        else
          render_at(COORD_W'($urandom), COORD_W'($urandom));
      end
    endcase
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: extreme colors and store ends, corners, outside hits.
    load_pixel(0, 24'h000000);
    load_pixel(STORE_DEPTH - 1, 24'hFFFFFF);
    load_pixel(16'h5A5A, 24'hA53CF0);
    render_at(0, 0);
    render_at(1023, 767);
    render_at(1024, 0);
    render_at(0, 768);
    render_at(12'hFFF, 12'hFFF);
    drain();

    // Smallest image and target, zero stride.
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_SRC_HEIGHT, 1);
    write_reg(REG_DST_WIDTH, 1);
    write_reg(REG_DST_HEIGHT, 1);
    write_reg(REG_DST_STRIDE, 0);
    render_at(0, 0);
    render_at(1, 0);
    render_at(0, 1);
    drain();

    // Oversized dimensions saturate; the largest stride wraps the offset.
    write_reg(REG_SRC_WIDTH, '1);
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(MAX_SRC_H));
    write_reg(REG_DST_WIDTH, '1);
    write_reg(REG_DST_HEIGHT, CFG_DATA_W'(MAX_DST_DIM));
    write_reg(REG_DST_STRIDE, '1);
    render_at(12'hFFF, 12'hFFF);
    render_at(0, 0);
    render_at(2048, 17);
    drain();

    // Writes past the last register, then zero dimensions.
    write_reg(REG_PAST_LAST, 13'h1ABC);
    write_reg(REG_PAST_LAST + 3'd2, 13'h0543);
    write_reg(REG_SRC_WIDTH, 0);
    render_at(0, 0);
    render_at(5, 5);
    drain();
    write_reg(REG_SRC_WIDTH, 3);
    write_reg(REG_DST_HEIGHT, 0);
    render_at(0, 0);
    drain();
    write_reg(REG_DST_HEIGHT, 5);
    render_at(0, 4);
    drain();

    // Long output hold while renders keep coming, so the input stalls.
    write_reg(REG_SRC_WIDTH, 16);
    write_reg(REG_SRC_HEIGHT, 12);
    write_reg(REG_DST_WIDTH, 800);
    write_reg(REG_DST_HEIGHT, 600);
    write_reg(REG_DST_STRIDE, 832);
    send_idle = 1'b0;
    hold_off_req = 1'b1;
    repeat (80) render_at(COORD_W'($urandom_range(0, 799)), COORD_W'($urandom_range(0, 599)));
    drain();

    // Random settings, each with a run of random words.
    for (int p = 0; p < 9; p++) begin
      random_setting();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      repeat (55) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("** cover_fit_nearest_scaler: PASSED **");
    else
      $display("** cover_fit_nearest_scaler: FAILED **");
    $finish;
  end

endmodule
